// ===== hw/rtl/dbm_pkg.sv =====
`timescale 1ns / 1ps

package dbm_pkg;

	// Factor and product sizes.
	localparam int MAX_DIGITS = 32;
	localparam int IDX_W = $clog2(MAX_DIGITS);
	localparam int LEN_W = $clog2(MAX_DIGITS + 1);
	localparam int COLS = 2 * MAX_DIGITS;
	localparam int COL_W = $clog2(COLS);
	localparam int DIGIT_W = 4;

	// Column sum and carry widths cover 32 * 81 plus the incoming carry.
	localparam int SUM_W = 12;
	localparam int CARRY_W = 9;

	// Division by ten as multiply by 3277 / 2^15, exact below 4096.
	localparam int RECIP_W = 12;
	localparam logic [RECIP_W-1:0] RECIP_TEN = 12'd3277;
	localparam int RECIP_SHIFT = 15;

	localparam logic [DIGIT_W-1:0] DIGIT_MAX = 4'd9;

	// Command queue between front and back.
	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W = $clog2(QUEUE_DEPTH);

	// Classified request kinds.
	typedef enum logic [1:0] {
		OP_STORE_A = 2'd0,
		OP_STORE_B = 2'd1,
		OP_RUN = 2'd2
	} op_t;

	typedef struct packed {
		op_t op;
		logic [DIGIT_W-1:0] digit;
	} cmd_t;

	// Front to queue.
	typedef struct packed {
		logic push;
		cmd_t cmd;
	} push_t;

	// Queue to back.
	typedef struct packed {
		logic empty;
		cmd_t head;
	} qstat_t;

endpackage

// ===== hw/rtl/dbm_front.sv =====
`timescale 1ns / 1ps

module dbm_front (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_stall,
	input  logic            func,
	input  logic [3:0]      digit,
	input  logic            last_in,
	input  logic            q_full,
	output dbm_pkg::push_t  push
);

	logic valid_s1;
	dbm_pkg::cmd_t cmd_s1;
	dbm_pkg::cmd_t cmd_in;
	logic accept;

	// Saturate the digit and tell the back end what the request asks for.
	always_comb begin
		cmd_in.digit = (digit > dbm_pkg::DIGIT_MAX) ? dbm_pkg::DIGIT_MAX : digit;
		if (!func) begin
			cmd_in.op = dbm_pkg::OP_STORE_A;
		end else if (last_in) begin
			cmd_in.op = dbm_pkg::OP_RUN;
		end else begin
			cmd_in.op = dbm_pkg::OP_STORE_B;
		end
	end

	// The held request blocks the input only while the queue is full.
	assign in_stall = valid_s1 && q_full;
	assign accept = in_valid && !in_stall;
	assign push.push = valid_s1 && !q_full;
	assign push.cmd = cmd_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (push.push) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_s1 <= cmd_in;
		end
	end

endmodule

// ===== hw/rtl/dbm_queue.sv =====
`timescale 1ns / 1ps

module dbm_queue (
	input  logic            clk,
	input  logic            arst_n,
	input  dbm_pkg::push_t  push,
	output logic            q_full,
	input  logic            pop,
	output dbm_pkg::qstat_t qstat
);

	localparam int QW = dbm_pkg::QPTR_W;
	localparam int CW = dbm_pkg::QPTR_W + 1;

	dbm_pkg::cmd_t entry_q [dbm_pkg::QUEUE_DEPTH];
	logic [QW-1:0] wr_ptr_q;
	logic [QW-1:0] rd_ptr_q;
	logic [CW-1:0] count_q;
	logic do_push;
	logic do_pop;

	assign q_full = (count_q == CW'(dbm_pkg::QUEUE_DEPTH));
	assign qstat.empty = (count_q == CW'(0));
	assign qstat.head = entry_q[rd_ptr_q];
	assign do_push = push.push && !q_full;
	assign do_pop = pop && !qstat.empty;

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + QW'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + QW'(1);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + CW'(1);
			end else if (!do_push && do_pop) begin
				count_q <= count_q - CW'(1);
			end
		end
	end

	// Entry storage.
	always_ff @(posedge clk) begin
		if (do_push) begin
			entry_q[wr_ptr_q] <= push.cmd;
		end
	end

endmodule

// ===== hw/rtl/dbm_back.sv =====
`timescale 1ns / 1ps

module dbm_back (
	input  logic            clk,
	input  logic            arst_n,
	input  dbm_pkg::qstat_t qstat,
	output logic            pop,
	output logic            out_valid,
	input  logic            out_stall,
	output logic [3:0]      product_digit,
	output logic            last_out,
	output logic            overflow
);

	localparam int IW = dbm_pkg::IDX_W;
	localparam int LW = dbm_pkg::LEN_W;
	localparam int CLW = dbm_pkg::COL_W;
	localparam int SW = dbm_pkg::SUM_W;
	localparam int KW = dbm_pkg::CARRY_W;
	localparam int DW = dbm_pkg::DIGIT_W;
	localparam int PW = dbm_pkg::SUM_W + dbm_pkg::RECIP_W;
	localparam int XW = dbm_pkg::COL_W + 1;

	typedef enum logic [5:0] {
		ST_IDLE    = 6'b000001,
		ST_COLSET  = 6'b000010,
		ST_PROD    = 6'b000100,
		ST_CARRY   = 6'b001000,
		ST_EMIT_RD = 6'b010000,
		ST_EMIT_WR = 6'b100000
	} state_t;

	state_t state_q;

	// Digit stores.
	logic [DW-1:0] fa_mem [dbm_pkg::MAX_DIGITS];
	logic [DW-1:0] fb_mem [dbm_pkg::MAX_DIGITS];
	logic [DW-1:0] dig_mem [dbm_pkg::COLS];
	logic [DW-1:0] rd_a_q;
	logic [DW-1:0] rd_b_q;
	logic [DW-1:0] rd_dig_q;

	logic [LW-1:0] la_q;
	logic [LW-1:0] lb_q;
	logic ov_q;

	logic [CLW-1:0] col_q;
	logic [LW-1:0] ra_q;
	logic [LW-1:0] ra_hi_q;
	logic rdv_q;
	logic [SW-1:0] acc_q;
	logic [KW-1:0] carry_q;
	logic [CLW-1:0] top_q;
	logic [CLW-1:0] k_q;

	logic out_valid_q;

	logic store_a;
	logic store_b;
	logic run;
	logic a_full;
	logic b_full;
	logic wr_a;
	logic wr_b;

	logic zero_len;
	logic [LW:0] len_sum;
	logic [CLW-1:0] last_col;
	logic [XW-1:0] colx;
	logic [XW-1:0] lax;
	logic [XW-1:0] lbx;
	logic [XW-1:0] lo_x;
	logic [XW-1:0] hi_x;
	logic col_empty;

	logic issue;
	logic [LW-1:0] a_pos;
	logic [XW-1:0] b_off;
	logic [XW-1:0] b_pos;
	logic [IW-1:0] a_addr;
	logic [IW-1:0] b_addr;

	logic [SW-1:0] tot;
	logic [PW-1:0] tot_scaled;
	logic [KW-1:0] quot;
	logic [SW-1:0] quot_x10;
	logic [DW-1:0] rem;
	logic at_last_col;

	logic load_out;

	// Request decode while idle.
	assign pop = (state_q == ST_IDLE) && !qstat.empty;
	assign store_a = pop && (qstat.head.op == dbm_pkg::OP_STORE_A);
	assign store_b = pop && ((qstat.head.op == dbm_pkg::OP_STORE_B) ||
		(qstat.head.op == dbm_pkg::OP_RUN));
	assign run = pop && (qstat.head.op == dbm_pkg::OP_RUN);
	assign a_full = (la_q == LW'(dbm_pkg::MAX_DIGITS));
	assign b_full = (lb_q == LW'(dbm_pkg::MAX_DIGITS));
	assign wr_a = store_a && !a_full;
	assign wr_b = store_b && !b_full;

	// Highest column and the product index range of the current column.
	assign zero_len = (la_q == LW'(0)) || (lb_q == LW'(0));
	assign len_sum = {1'b0, la_q} + {1'b0, lb_q};
	assign last_col = zero_len ? CLW'(0) : CLW'(len_sum - (LW + 1)'(1));
	assign colx = XW'(col_q);
	assign lax = XW'(la_q);
	assign lbx = XW'(lb_q);
	assign lo_x = (colx >= lbx) ? (colx + XW'(1) - lbx) : XW'(0);
	assign hi_x = (colx < lax) ? colx : (lax - XW'(1));
	assign col_empty = zero_len || (lo_x > hi_x);

	// Digit addresses for one product of the column.
	assign issue = (state_q == ST_PROD) && (ra_q <= ra_hi_q);
	assign a_pos = la_q - LW'(1) - ra_q;
	assign b_off = colx - XW'(ra_q);
	assign b_pos = lbx - XW'(1) - b_off;
	assign a_addr = a_pos[IW-1:0];
	assign b_addr = b_pos[IW-1:0];

	// Carry step: split column sum plus carry into a digit and a new carry.
	assign tot = acc_q + SW'(carry_q);
	assign tot_scaled = PW'(tot) * PW'(dbm_pkg::RECIP_TEN);
	assign quot = KW'(tot_scaled >> dbm_pkg::RECIP_SHIFT);
	assign quot_x10 = SW'({quot, 3'b000}) + SW'({quot, 1'b0});
	assign rem = DW'(tot - quot_x10);
	assign at_last_col = (col_q == last_col);

	assign load_out = (state_q == ST_EMIT_WR) && (!out_valid_q || !out_stall);

	// Factor stores written in order, read one product at a time.
	always_ff @(posedge clk) begin
		if (wr_a) begin
			fa_mem[la_q[IW-1:0]] <= qstat.head.digit;
		end
		if (wr_b) begin
			fb_mem[lb_q[IW-1:0]] <= qstat.head.digit;
		end
		rd_a_q <= fa_mem[a_addr];
		rd_b_q <= fb_mem[b_addr];
	end

	// Product digits, least significant first.
	always_ff @(posedge clk) begin
		if (state_q == ST_CARRY) begin
			dig_mem[col_q] <= rem;
		end
		rd_dig_q <= dig_mem[k_q];
	end

	// Sequencer: store, column sums, carry pass, emission.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			la_q <= '0;
			lb_q <= '0;
			ov_q <= 1'b0;
			col_q <= '0;
			ra_q <= '0;
			ra_hi_q <= '0;
			rdv_q <= 1'b0;
			acc_q <= '0;
			carry_q <= '0;
			top_q <= '0;
			k_q <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (wr_a) begin
						la_q <= la_q + LW'(1);
					end
					if (wr_b) begin
						lb_q <= lb_q + LW'(1);
					end
					if ((store_a && a_full) || (store_b && b_full)) begin
						ov_q <= 1'b1;
					end
					if (run) begin
						col_q <= '0;
						carry_q <= '0;
						top_q <= '0;
						state_q <= ST_COLSET;
					end
				end
				ST_COLSET: begin
					acc_q <= '0;
					rdv_q <= 1'b0;
					ra_q <= LW'(lo_x);
					ra_hi_q <= LW'(hi_x);
					state_q <= col_empty ? ST_CARRY : ST_PROD;
				end
				ST_PROD: begin
					if (rdv_q) begin
						acc_q <= acc_q + SW'(rd_a_q * rd_b_q);
					end
					rdv_q <= issue;
					if (issue) begin
						ra_q <= ra_q + LW'(1);
					end else if (!rdv_q) begin
						state_q <= ST_CARRY;
					end
				end
				ST_CARRY: begin
					carry_q <= quot;
					if (rem != DW'(0)) begin
						top_q <= col_q;
					end
					if (at_last_col) begin
						k_q <= (rem != DW'(0)) ? col_q : top_q;
						state_q <= ST_EMIT_RD;
					end else begin
						col_q <= col_q + CLW'(1);
						state_q <= ST_COLSET;
					end
				end
				ST_EMIT_RD: begin
					state_q <= ST_EMIT_WR;
				end
				ST_EMIT_WR: begin
					if (load_out) begin
						if (k_q == CLW'(0)) begin
							la_q <= '0;
							lb_q <= '0;
							ov_q <= 1'b0;
							state_q <= ST_IDLE;
						end else begin
							k_q <= k_q - CLW'(1);
							state_q <= ST_EMIT_RD;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			product_digit <= rd_dig_q;
			last_out <= (k_q == CLW'(0));
			overflow <= ov_q;
		end
	end

	assign out_valid = out_valid_q;

endmodule

// ===== hw/rtl/decimal_bignum_multiplier.sv =====
`timescale 1ns / 1ps
// Channel   Handshake             Payload
// input     in_valid / in_stall   func, digit, last_in
// output    out_valid / out_stall product_digit, last_out, overflow
//
// A digit request is taken by the back end while it is idle. A request that ends
// the second factor starts a run over la + lb columns, each summed by the single
// shared digit-product accumulator and then passed through the carry step; each
// product digit is then read out through the digit store read port, subject to
// any output stall.
// Reset is asynchronous and active low; no memory is cleared after reset.
// A four-entry request queue lets input flow on while a run stalls on output.

module decimal_bignum_multiplier (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic       func,
	input  logic [3:0] digit,
	input  logic       last_in,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [3:0] product_digit,
	output logic       last_out,
	output logic       overflow
);

	dbm_pkg::push_t push;
	dbm_pkg::qstat_t qstat;
	logic q_full;
	logic pop;

	dbm_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.func     (func),
		.digit    (digit),
		.last_in  (last_in),
		.q_full   (q_full),
		.push     (push)
	);

	dbm_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.q_full (q_full),
		.pop    (pop),
		.qstat  (qstat)
	);

	dbm_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.qstat         (qstat),
		.pop           (pop),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.product_digit (product_digit),
		.last_out      (last_out),
		.overflow      (overflow)
	);

endmodule

// ===== hw/rtl/dbm_checker.sv =====
`timescale 1ns / 1ps

module dbm_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       out_valid,
	input logic       out_stall,
	input logic [3:0] product_digit,
	input logic       last_out,
	input logic       overflow
);

	logic first_q;
	logic run_ov_q;

	// Track where each product starts and its overflow flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			first_q <= 1'b1;
			run_ov_q <= 1'b0;
		end else if (out_valid && !out_stall) begin
			first_q <= last_out;
			run_ov_q <= overflow;
		end
	end

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(product_digit) &&
		$stable(last_out) && $stable(overflow))
		else $error("stalled result changed");

	a_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> product_digit <= 4'd9)
		else $error("product digit above nine");

	a_lead: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && first_q && product_digit == 4'd0 |-> last_out)
		else $error("leading zero in product");

	a_ov: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !first_q |-> overflow == run_ov_q)
		else $error("overflow flag changed within a product");

endmodule

bind decimal_bignum_multiplier dbm_checker u_checker (.*);
